@@ hw/rtl/hmm_viterbi_scorer_defines.svh @@
// assertion macros for the hmm viterbi scorer
`ifndef HMM_VITERBI_SCORER_DEFINES_SVH
`define HMM_VITERBI_SCORER_DEFINES_SVH
`ifndef SYNTHESIS
`define HVS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define HVS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`else
`define HVS_ASSERT(label, clk, rst_n, prop)
`define HVS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/hvs_pkg.sv @@
// package with shared types and constants of the hmm viterbi scorer
`timescale 1ns / 1ps
package hvs_pkg;
	localparam int MAX_STATES    = 8;
	localparam int CODEBOOK_SIZE = 32;

	localparam logic [1:0] FUNC_TRANS = 2'd0;
	localparam logic [1:0] FUNC_EMIT  = 2'd1;
	localparam logic [1:0] FUNC_INIT  = 2'd2;
	localparam logic [1:0] FUNC_OBS   = 2'd3;
	localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  row_state;
		logic [2:0]  col_state;
		logic [4:0]  symbol;
		logic [15:0] log_value;
		logic        first;
		logic        last;
	} item_t;

	function automatic logic signed [31:0] q88_to_score(input logic [15:0] raw);
		if (raw == 16'h8000) begin
			return NEG_INF;
		end
		return {{16{raw[15]}}, raw};
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (a == NEG_INF || b == NEG_INF) begin
			return NEG_INF;
		end
		if (s > 33'sh0_7fff_ffff) begin
			return POS_MAX;
		end
		if (s < -33'sh0_8000_0000) begin
			return NEG_INF;
		end
		return s[31:0];
	endfunction
endpackage

@@ hw/rtl/hvs_front.sv @@
// front end: input queue of accepted transactions
`timescale 1ns / 1ps
module hvs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  hvs_pkg::item_t in_item,
	output logic           q_valid,
	input  logic           q_take,
	output hvs_pkg::item_t q_item
);
	hvs_pkg::item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

@@ hw/rtl/hvs_core.sv @@
// back end: table storage and shared add-compare unit for the viterbi recursion
`timescale 1ns / 1ps
`include "hmm_viterbi_scorer_defines.svh"
module hvs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          active_states,
	input  logic                q_valid,
	output logic                q_take,
	input  hvs_pkg::item_t      q_item,
	output logic                res_valid,
	input  logic                res_take,
	output logic signed [31:0]  res_score,
	output logic [2:0]          res_state
);
	localparam int MAX_STATES    = hvs_pkg::MAX_STATES;
	localparam int CODEBOOK_SIZE = hvs_pkg::CODEBOOK_SIZE;
	localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int CW = (CODEBOOK_SIZE > 1) ? $clog2(CODEBOOK_SIZE) : 1;
	localparam int CNTW = SW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_DEST, S_SRC, S_EMIT, S_FINAL, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] trans_mem [MAX_STATES*MAX_STATES];
	logic [15:0] emit_mem [MAX_STATES*CODEBOOK_SIZE];
	logic [15:0] init_mem [MAX_STATES];
	logic signed [31:0] score_q [MAX_STATES];
	logic signed [31:0] next_q [MAX_STATES];

	hvs_pkg::item_t item_q;
	logic [CNTW-1:0] n_q;
	logic [CNTW-1:0] j_q, i_q;
	logic signed [31:0] best_q;
	logic [15:0] trans_rd_q, emit_rd_q;
	logic rd_ok_q;
	logic [2:0] best_state_q;
	logic res_valid_q;
	logic signed [31:0] res_score_q;
	logic [2:0] res_state_q;

	logic [CNTW-1:0] n_eff;
	logic row_ok, col_ok, sym_ok;
	logic signed [31:0] cand;
	logic out_load;

	assign row_ok = ({1'b0, q_item.row_state} < 4'(MAX_STATES));
	assign col_ok = ({1'b0, q_item.col_state} < 4'(MAX_STATES));
	assign sym_ok = ({3'b0, q_item.symbol} < 8'(CODEBOOK_SIZE));

	always_comb begin
		if (active_states == 4'd0) begin
			n_eff = CNTW'(1);
		end else if ({1'b0, active_states} > 5'(MAX_STATES)) begin
			n_eff = CNTW'(MAX_STATES);
		end else begin
			n_eff = CNTW'(active_states);
		end
	end

	assign q_take = (state_q == S_IDLE) && q_valid;
	assign out_load = (state_q == S_OUT) && (!res_valid_q || res_take);
	assign res_valid = res_valid_q;
	assign res_score = res_score_q;
	assign res_state = res_state_q;

	assign cand = hvs_pkg::sat_add(score_q[i_q[SW-1:0]],
		hvs_pkg::q88_to_score(trans_rd_q));

	// table writes
	always_ff @(posedge clk) begin
		if (q_take) begin
			case (q_item.func)
				hvs_pkg::FUNC_TRANS: begin
					if (row_ok && col_ok) begin
						trans_mem[{q_item.row_state[SW-1:0], q_item.col_state[SW-1:0]}]
							<= q_item.log_value;
					end
				end
				hvs_pkg::FUNC_EMIT: begin
					if (row_ok && sym_ok) begin
						emit_mem[{q_item.row_state[SW-1:0], q_item.symbol[CW-1:0]}]
							<= q_item.log_value;
					end
				end
				hvs_pkg::FUNC_INIT: begin
					if (row_ok) begin
						init_mem[q_item.row_state[SW-1:0]] <= q_item.log_value;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// registered table reads, address by next step
	always_ff @(posedge clk) begin
		trans_rd_q <= trans_mem[{i_q[SW-1:0], j_q[SW-1:0]}];
		emit_rd_q <= emit_mem[{j_q[SW-1:0], item_q.symbol[CW-1:0]}];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_score_q <= '0;
			res_state_q <= '0;
		end else begin
			res_valid_q <= out_load || (res_valid_q && !res_take);
			if (out_load) begin
				res_score_q <= best_q;
				res_state_q <= best_state_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			i_q <= '0;
			n_q <= '0;
			rd_ok_q <= 1'b0;
			item_q <= '0;
			best_q <= '0;
			best_state_q <= '0;
			for (int k = 0; k < MAX_STATES; k++) begin
				score_q[k] <= '0;
				next_q[k] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_take && q_item.func == hvs_pkg::FUNC_OBS) begin
						item_q <= q_item;
						n_q <= n_eff;
						j_q <= '0;
						i_q <= '0;
						rd_ok_q <= 1'b0;
						best_q <= hvs_pkg::NEG_INF;
						state_q <= S_DEST;
					end
				end
				S_DEST: begin
					// wait for registered reads of (i=0, j)
					if (j_q >= n_q) begin
						next_q[j_q[SW-1:0]] <= hvs_pkg::NEG_INF;
						if (j_q == CNTW'(MAX_STATES - 1)) begin
							j_q <= '0;
							best_q <= hvs_pkg::NEG_INF;
							best_state_q <= '0;
							state_q <= S_FINAL;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else if (rd_ok_q) begin
						rd_ok_q <= 1'b0;
						if (item_q.first) begin
							state_q <= S_EMIT;
						end else begin
							best_q <= hvs_pkg::NEG_INF;
							state_q <= S_SRC;
						end
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				S_SRC: begin
					if (rd_ok_q) begin
						rd_ok_q <= 1'b0;
						if (i_q == '0 || cand > best_q) begin
							best_q <= cand;
						end
						if (i_q + 1'b1 >= n_q) begin
							i_q <= '0;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (rd_ok_q) begin
						rd_ok_q <= 1'b0;
						next_q[j_q[SW-1:0]] <= hvs_pkg::sat_add(
							item_q.first ? hvs_pkg::q88_to_score(init_mem[j_q[SW-1:0]])
								: best_q,
							({1'b0, item_q.symbol} < 6'(CODEBOOK_SIZE))
								? hvs_pkg::q88_to_score(emit_rd_q) : hvs_pkg::NEG_INF);
						if (j_q == CNTW'(MAX_STATES - 1)) begin
							j_q <= '0;
							best_q <= hvs_pkg::NEG_INF;
							best_state_q <= '0;
							state_q <= S_FINAL;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_DEST;
						end
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				S_FINAL: begin
					score_q[j_q[SW-1:0]] <= next_q[j_q[SW-1:0]];
					if (j_q < n_q && (j_q == '0 || next_q[j_q[SW-1:0]] > best_q)) begin
						best_q <= next_q[j_q[SW-1:0]];
						best_state_q <= 3'(j_q);
					end
					if (j_q == CNTW'(MAX_STATES - 1)) begin
						j_q <= '0;
						state_q <= item_q.last ? S_OUT : S_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HVS_ASSERT(a_take_idle, clk, arst_n, q_take |-> state_q == S_IDLE)
	`HVS_ASSERT(a_out_holds, clk, arst_n, (res_valid && !res_take) |=> res_valid)
	`HVS_ASSERT(a_out_stable, clk, arst_n, (res_valid && !res_take) |=> $stable(res_score))
	`HVS_ASSERT_NEVER(a_state_range, clk, arst_n, res_valid && ({1'b0, res_state} >= n_q))
endmodule

@@ hw/rtl/hmm_viterbi_scorer.sv @@
// top level of the hmm viterbi scorer
// the core scores one accepted observation at a time over N active states and takes no new item
// until it is done; loads are taken one per cycle behind the two-entry queue while the core is idle
// a first observation skips the source scan; a last one also waits until the result register is free
// arst_n clears control state and sets active_states to 8; tables hold garbage until loaded
`timescale 1ns / 1ps
module hmm_viterbi_scorer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [2:0]         row_state,
	input  logic [2:0]         col_state,
	input  logic [4:0]         symbol,
	input  logic signed [15:0] log_value,
	input  logic               first,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] best_score,
	output logic [2:0]         best_state,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	hvs_pkg::item_t in_item, q_item;
	logic q_valid, q_take, res_valid;
	logic [3:0] active_states_q;

	assign in_item = '{func: func, row_state: row_state, col_state: col_state,
		symbol: symbol, log_value: log_value, first: first, last: last};
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {28'd0, active_states_q} : 32'd0;
	assign empty = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_states_q <= 4'd8;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			active_states_q <= pwdata[3:0];
		end
	end

	hvs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	hvs_core u_core (
		.clk(clk), .arst_n(arst_n), .active_states(active_states_q),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.res_valid(res_valid), .res_take(pop), .res_score(best_score),
		.res_state(best_state)
	);
endmodule

@@ tb/tb_hmm_viterbi_scorer.sv @@
// testbench for the hmm viterbi scorer: random loads and observations against a predictor
`timescale 1ns / 1ps
module tb_hmm_viterbi_scorer;
	localparam int NS = 8;
	localparam int NSYM = 32;
	localparam int NSEL = 4;
	localparam int DRAIN_CYCLES = 3 * NS * NS + 3 * NS + NS + 40;
	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] ADDR_ACTIVE = 2'd0;

	typedef struct packed {
		logic signed [31:0] score;
		logic [2:0]         state;
	} best_t;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [1:0] func;
	logic [2:0] row_state, col_state;
	logic [4:0] symbol;
	logic signed [15:0] log_value;
	logic first, last;
	logic signed [31:0] best_score;
	logic [2:0] best_state;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;

	hmm_viterbi_scorer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.row_state(row_state), .col_state(col_state), .symbol(symbol),
		.log_value(log_value), .first(first), .last(last), .empty(empty), .pop(pop),
		.best_score(best_score), .best_state(best_state), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	hvs_pkg::item_t pending_items[$];
	best_t expected_best[$];
	logic signed [31:0] pred_path[NS];
	logic [15:0] pred_trans[NS * NS];
	logic [15:0] pred_emit[NS * NSYM];
	logic [15:0] pred_init[NS];
	int sym_set[NSEL] = '{0, 5, 9, 31};
	int pred_active;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	bit timed_out = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] to_score(logic [15:0] raw);
		if (raw == 16'h8000) return hvs_pkg::NEG_INF;
		return {{16{raw[15]}}, raw};
	endfunction

	function automatic logic signed [31:0] add_sat(logic signed [31:0] a,
		logic signed [31:0] b);
		longint s;
		if (a == hvs_pkg::NEG_INF || b == hvs_pkg::NEG_INF) return hvs_pkg::NEG_INF;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) return hvs_pkg::POS_MAX;
		if (s < -64'sd2147483648) return hvs_pkg::NEG_INF;
		return s[31:0];
	endfunction

	task automatic predict_item(hvs_pkg::item_t it);
		logic signed [31:0] nxt[NS];
		logic signed [31:0] best, c, em;
		int bj;
		best_t bt;
		case (it.func)
			hvs_pkg::FUNC_TRANS: pred_trans[it.row_state * NS + it.col_state] = it.log_value;
			hvs_pkg::FUNC_EMIT: pred_emit[it.row_state * NSYM + it.symbol] = it.log_value;
			hvs_pkg::FUNC_INIT: pred_init[it.row_state] = it.log_value;
			default: begin
				for (int j = 0; j < NS; j++) begin
					em = to_score(pred_emit[j * NSYM + it.symbol]);
					if (j >= pred_active) nxt[j] = hvs_pkg::NEG_INF;
					else if (it.first) nxt[j] = add_sat(to_score(pred_init[j]), em);
					else begin
						best = add_sat(pred_path[0], to_score(pred_trans[j]));
						for (int i = 1; i < pred_active; i++) begin
							c = add_sat(pred_path[i], to_score(pred_trans[i * NS + j]));
							if (c > best) best = c;
						end
						nxt[j] = add_sat(best, em);
					end
				end
				pred_path = nxt;
				if (it.last) begin
					bj = 0;
					for (int j = 1; j < pred_active; j++)
						if (pred_path[j] > pred_path[bj]) bj = j;
					bt.score = pred_path[bj];
					bt.state = 3'(bj);
					expected_best.insert(expected_best.size(), bt);
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_item(pending_items.pop_front());
			end
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1;
				{func, row_state, col_state, symbol, log_value, first, last}
					<= pending_items[0];
			end else begin
				push <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		best_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_best.size() == 0) begin
					report_mismatch("unexpected result", best_score, 0);
				end else begin
					want = expected_best.pop_front();
					if (best_score !== want.score)
						report_mismatch("best_score", best_score, want.score);
					if (best_state !== want.state)
						report_mismatch("best_state", 32'(best_state), 32'(want.state));
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_active(int n);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= ADDR_ACTIVE; pwdata <= n; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		pred_active = (n < 1) ? 1 : (n > NS ? NS : n);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || push || expected_best.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_log();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h0000;
			2: return 16'h7fff;
			3: return 16'($urandom_range(65535));
			default: return -16'($urandom_range(2048));
		endcase
	endfunction

	function automatic int pick_sym();
		return sym_set[$urandom_range(NSEL - 1)];
	endfunction

	function automatic hvs_pkg::item_t mk(logic [1:0] f, int r, int c, int s,
		logic [15:0] v, bit fi, bit la);
		hvs_pkg::item_t it;
		it.func = f; it.row_state = 3'(r); it.col_state = 3'(c); it.symbol = 5'(s);
		it.log_value = v; it.first = fi; it.last = la;
		return it;
	endfunction

	task automatic add_item(hvs_pkg::item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// table load covering every entry that observations read
	task automatic queue_tables(bit extreme);
		for (int r = 0; r < NS; r++) begin
			add_item(mk(hvs_pkg::FUNC_INIT, r, $urandom_range(7), $urandom_range(31),
				extreme ? 16'h7fff : rand_log(), $urandom_range(1), $urandom_range(1)));
			for (int c = 0; c < NS; c++)
				add_item(mk(hvs_pkg::FUNC_TRANS, r, c, $urandom_range(31),
					extreme ? 16'h7fff : rand_log(), $urandom_range(1), $urandom_range(1)));
			for (int k = 0; k < NSEL; k++)
				add_item(mk(hvs_pkg::FUNC_EMIT, r, $urandom_range(7), sym_set[k],
					extreme ? 16'h7fff : rand_log(), $urandom_range(1), $urandom_range(1)));
		end
	endtask

	task automatic queue_sequences(int count);
		int len;
		for (int k = 0; k < count; k++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
			for (int t = 0; t < len; t++)
				add_item(mk(hvs_pkg::FUNC_OBS, $urandom_range(7), $urandom_range(7),
					pick_sym(), 16'($urandom_range(65535)), t == 0, t == len - 1));
			if ($urandom_range(5) == 0)
				add_item(mk(2'($urandom_range(2)), $urandom_range(7),
					$urandom_range(7), $urandom_range(31), rand_log(), $urandom_range(1),
					$urandom_range(1)));
		end
	endtask

	initial begin
		int settings[6] = '{8, 1, 0, 15, 3, 5};
		push = 0; pop = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		func = 0; row_state = 0; col_state = 0; symbol = 0; log_value = 0;
		first = 0; last = 0;
		pred_active = NS;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// maximum table entries, then min tables and extremes of every field
		queue_tables(1);
		add_item(mk(hvs_pkg::FUNC_OBS, 0, 0, 31, 0, 1, 0));
		add_item(mk(hvs_pkg::FUNC_OBS, 7, 7, 0, 16'hffff, 0, 1));
		add_item(mk(hvs_pkg::FUNC_OBS, 0, 0, 5, 0, 1, 1));
		wait_idle();
		for (int r = 0; r < NS; r++) begin
			add_item(mk(hvs_pkg::FUNC_INIT, r, 0, 0, 16'h8000, 0, 0));
			for (int c = 0; c < NS; c++)
				add_item(mk(hvs_pkg::FUNC_TRANS, r, c, 0,
					(c == r) ? 16'h0000 : 16'h8000, 1, 1));
			for (int k = 0; k < NSEL; k++)
				add_item(mk(hvs_pkg::FUNC_EMIT, r, 0, sym_set[k], 16'h8000, 0, 0));
		end
		add_item(mk(hvs_pkg::FUNC_OBS, 0, 0, 31, 0, 1, 1));
		add_item(mk(hvs_pkg::FUNC_INIT, 3, 0, 0, 16'h0000, 0, 0));
		add_item(mk(hvs_pkg::FUNC_EMIT, 3, 0, 9, 16'h0000, 0, 0));
		add_item(mk(hvs_pkg::FUNC_OBS, 0, 0, 9, 0, 1, 0));
		add_item(mk(hvs_pkg::FUNC_OBS, 0, 0, 9, 0, 0, 1));
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			write_active(settings[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 83; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 83; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			if (ph % 3 == 0) queue_tables(0);
			queue_sequences(10);
			wait_idle();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/hvs_pkg.sv
hw/rtl/hvs_front.sv
hw/rtl/hvs_core.sv
hw/rtl/hmm_viterbi_scorer.sv
tb/tb_hmm_viterbi_scorer.sv
